@@ sv/ivbt_pkg.sv @@
package ivbt_pkg;

    // The slot count must be a power of two so that the home slot is a mask of the hash.
    localparam int TABLE_SLOTS = 64;
    localparam int PROBE_DEPTH = 8;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(PROBE_DEPTH + 1);

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    localparam logic [2:0] REQ_CHECK     = 3'd0;
    localparam logic [2:0] REQ_TRACK     = 3'd1;
    localparam logic [2:0] REQ_REPORT    = 3'd2;
    localparam logic [2:0] REQ_BAN_DEF   = 3'd3;
    localparam logic [2:0] REQ_BAN_TIMED = 3'd4;
    localparam logic [2:0] REQ_UNBAN     = 3'd5;
    localparam logic [2:0] REQ_TICK      = 3'd6;

    localparam logic [2:0] CFG_MAX_STRIKES   = 3'd0;
    localparam logic [2:0] CFG_WINDOW        = 3'd1;
    localparam logic [2:0] CFG_BAN_SECS      = 3'd2;
    localparam logic [2:0] CFG_RATE_LIMITED  = 3'd3;
    localparam logic [2:0] CFG_CLIENT_ERRORS = 3'd4;
    localparam logic [2:0] CFG_SERVER_ERRORS = 3'd5;

    localparam logic [9:0] STATUS_429 = 10'd429;
    localparam logic [9:0] STATUS_400 = 10'd400;
    localparam logic [9:0] STATUS_500 = 10'd500;

    typedef struct packed {
        logic [31:0] addr;
        logic        ban_active;
        logic [31:0] ban_until;
        logic        strikes_active;
        logic [15:0] strikes;
        logic [31:0] strikes_until;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ sv/ivbt_if.sv @@
interface ivbt_req_if;
    import ivbt_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] client_ip;
    logic [9:0]  resp_status;
    logic        path_matched;
    logic [7:0]  weight;
    logic [31:0] ban_seconds;

    modport source (output valid, req_type, client_ip, resp_status, path_matched, weight,
                    ban_seconds, input ready);
    modport sink (input valid, req_type, client_ip, resp_status, path_matched, weight,
                  ban_seconds, output ready);
endinterface

interface ivbt_res_if;
    import ivbt_pkg::*;
    logic        valid;
    logic        ready;
    logic        is_blocked;
    logic [15:0] strike_count;
    logic        just_banned;
    logic        table_full;

    modport source (output valid, is_blocked, strike_count, just_banned, table_full,
                    input ready);
    modport sink (input valid, is_blocked, strike_count, just_banned, table_full,
                  output ready);
endinterface

@@ sv/ip_violation_ban_table.sv @@
// Per-address violation and ban table. One item is taken at a time and gives one result
// item. The hash product is registered at acceptance, the probe then reads successive
// slots through the registered read port of the entry memory, and a write-back state
// follows; the result then waits in its register until taken. The next item can be
// accepted in the cycle after the result is taken. No clearing pass is needed after
// reset; slot occupancy is kept in flip-flops that reset clears.
module ip_violation_ban_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    ivbt_req_if.sink    req,
    ivbt_res_if.source  res
);
    import ivbt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_WB    = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [15:0] max_strikes_reg;
    logic [31:0] window_reg, ban_secs_reg;
    logic        rate_lim_reg, client_err_reg, server_err_reg;
    logic [31:0] now_reg, now_next;
    logic [TABLE_SLOTS-1:0] used_reg;

    logic [2:0]  type_reg;
    logic [31:0] ip_reg, secs_reg;
    logic [9:0]  status_reg;
    logic        pm_reg;
    logic [7:0]  wt_reg;

    logic [CNT_W-1:0]     cnt_reg;
    logic [SLOT_BITS-1:0] rd_idx_reg, base_slot, rd_addr;
    logic                 hit_reg, free_reg;
    logic [SLOT_BITS-1:0] hit_idx_reg, free_idx_reg;
    entry_t               hit_data_reg, rd_data;

    logic        blocked_reg, just_reg, full_reg;
    logic [15:0] count_reg;

    logic accept;
    logic [ENTRY_W-1:0] rd_raw;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_OUT);
    assign res.is_blocked   = blocked_reg;
    assign res.strike_count = count_reg;
    assign res.just_banned  = just_reg;
    assign res.table_full   = full_reg;

    ivbt_hash u_hash (
        .clk  (clk),
        .load (accept),
        .ip   (req.client_ip),
        .slot (base_slot)
    );

    assign rd_addr = base_slot + SLOT_BITS'(cnt_reg);

    // Write-back logic.
    entry_t               base_ent, new_ent;
    logic                 tgt_found, ram_we, used_set, used_clr, present;
    logic                 just_c, full_c, counted, is_add;
    logic [SLOT_BITS-1:0] tgt_idx;
    logic [7:0]           w;
    logic [16:0]          c17;
    logic [15:0]          csat;

    ivbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_idx),
        .wdata (new_ent),
        .raddr (rd_addr),
        .rdata (rd_raw)
    );

    assign rd_data = entry_t'(rd_raw);

    // Probe evaluation of the entry read in the previous cycle.
    logic rd_used, rd_match, rd_dead;
    assign rd_used  = used_reg[rd_idx_reg];
    assign rd_match = rd_used && (rd_data.addr == ip_reg);
    assign rd_dead  = !rd_used ||
                      (!(rd_data.ban_active && now_reg < rd_data.ban_until) &&
                       !(rd_data.strikes_active && now_reg < rd_data.strikes_until));

    always_comb
    begin
        now_next = now_reg;
        if (type_reg == REQ_TICK)
        begin
            now_next = sat_add32(now_reg, 32'd1);
        end

        tgt_found = hit_reg || free_reg;
        tgt_idx   = hit_reg ? hit_idx_reg : free_idx_reg;
        base_ent  = hit_data_reg;
        if (!hit_reg)
        begin
            base_ent      = '0;
            base_ent.addr = ip_reg;
        end

        counted = (rate_lim_reg && status_reg == STATUS_429) ||
                  (client_err_reg && status_reg >= STATUS_400 && status_reg < STATUS_500 &&
                   status_reg != STATUS_429) ||
                  (server_err_reg && status_reg >= STATUS_500);
        is_add  = (type_reg == REQ_TRACK && counted) || type_reg == REQ_REPORT;
        w       = (type_reg == REQ_TRACK && !pm_reg) ? 8'd1 : wt_reg;

        c17 = {1'b0, (base_ent.strikes_active && now_reg < base_ent.strikes_until) ?
                      base_ent.strikes : 16'd0} + {9'd0, w};
        csat = c17[16] ? 16'hFFFF : c17[15:0];

        new_ent  = base_ent;
        ram_we   = 1'b0;
        used_set = 1'b0;
        used_clr = 1'b0;
        just_c   = 1'b0;
        full_c   = 1'b0;
        present  = hit_reg;

        case (type_reg)
            REQ_TRACK, REQ_REPORT:
            begin
                if (is_add && !(hit_reg && hit_data_reg.ban_active &&
                                now_reg < hit_data_reg.ban_until))
                begin
                    if (!tgt_found)
                    begin
                        full_c = 1'b1;
                    end
                    else
                    begin
                        new_ent.strikes        = csat;
                        new_ent.strikes_active = 1'b1;
                        new_ent.strikes_until  = sat_add32(now_reg, window_reg);
                        if (csat >= max_strikes_reg)
                        begin
                            new_ent.ban_active     = 1'b1;
                            new_ent.ban_until      = sat_add32(now_reg, ban_secs_reg);
                            new_ent.strikes_active = 1'b0;
                            new_ent.strikes        = 16'd0;
                            just_c                 = 1'b1;
                        end
                        ram_we   = 1'b1;
                        used_set = 1'b1;
                        present  = 1'b1;
                    end
                end
            end
            REQ_BAN_DEF, REQ_BAN_TIMED:
            begin
                if (!tgt_found)
                begin
                    full_c = 1'b1;
                end
                else
                begin
                    new_ent.ban_active = 1'b1;
                    new_ent.ban_until  = sat_add32(now_reg, (type_reg == REQ_BAN_DEF) ?
                                                   ban_secs_reg : secs_reg);
                    ram_we   = 1'b1;
                    used_set = 1'b1;
                    present  = 1'b1;
                end
            end
            REQ_UNBAN:
            begin
                if (hit_reg)
                begin
                    new_ent.ban_active     = 1'b0;
                    new_ent.strikes_active = 1'b0;
                    new_ent.strikes        = 16'd0;
                    ram_we   = 1'b1;
                    used_clr = 1'b1;
                    present  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (state_reg != S_WB)
        begin
            ram_we   = 1'b0;
            used_set = 1'b0;
            used_clr = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (cnt_reg == CNT_W'(PROBE_DEPTH))
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_strikes_reg <= 16'd10;
            window_reg      <= 32'd300;
            ban_secs_reg    <= 32'd3600;
            rate_lim_reg    <= 1'b1;
            client_err_reg  <= 1'b1;
            server_err_reg  <= 1'b0;
            now_reg         <= 32'd0;
            used_reg        <= '0;
            cnt_reg         <= '0;
            hit_reg         <= 1'b0;
            free_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_STRIKES:   max_strikes_reg <= cfg_data[15:0];
                    CFG_WINDOW:        window_reg      <= cfg_data;
                    CFG_BAN_SECS:      ban_secs_reg    <= cfg_data;
                    CFG_RATE_LIMITED:  rate_lim_reg    <= cfg_data[0];
                    CFG_CLIENT_ERRORS: client_err_reg  <= cfg_data[0];
                    CFG_SERVER_ERRORS: server_err_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                cnt_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            if (state_reg == S_PROBE)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg != '0)
                begin
                    if (!hit_reg && rd_match)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (!free_reg && rd_dead)
                    begin
                        free_reg <= 1'b1;
                    end
                end
            end
            if (state_reg == S_WB)
            begin
                now_reg <= now_next;
            end
            if (used_set)
            begin
                used_reg[tgt_idx] <= 1'b1;
            end
            if (used_clr)
            begin
                used_reg[tgt_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg   <= req.req_type;
            ip_reg     <= req.client_ip;
            status_reg <= req.resp_status;
            pm_reg     <= req.path_matched;
            wt_reg     <= req.weight;
            secs_reg   <= req.ban_seconds;
        end
        if (state_reg == S_PROBE)
        begin
            rd_idx_reg <= rd_addr;
            if (cnt_reg != '0)
            begin
                if (!hit_reg && rd_match)
                begin
                    hit_idx_reg  <= rd_idx_reg;
                    hit_data_reg <= rd_data;
                end
                if (!free_reg && rd_dead)
                begin
                    free_idx_reg <= rd_idx_reg;
                end
            end
        end
        if (state_reg == S_WB)
        begin
            blocked_reg <= present && new_ent.ban_active && now_next < new_ent.ban_until;
            count_reg   <= (present && new_ent.strikes_active &&
                            now_next < new_ent.strikes_until) ? new_ent.strikes : 16'd0;
            just_reg    <= just_c;
            full_reg    <= full_c;
        end
    end

`ifndef SYNTHESIS
    a_out_only_after_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg) == S_WB)
        else $error("result shown without a write-back cycle");
    a_accept_starts_probe: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_PROBE && cnt_reg == '0)
        else $error("accepted item did not start a probe");
    a_write_in_wb: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_WB && (hit_reg || free_reg))
        else $error("entry write without a target slot");
    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB && full_c) |-> !ram_we && !hit_reg && !free_reg)
        else $error("table full flagged with a slot available");
`endif
endmodule

@@ sv/ivbt_ram.sv @@
module ivbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/ivbt_hash.sv @@
module ivbt_hash (
    input  logic                           clk,
    input  logic                           load,
    input  logic [31:0]                    ip,
    output logic [ivbt_pkg::SLOT_BITS-1:0] slot
);
    import ivbt_pkg::*;

    logic [31:0] prod_reg;
    logic [31:0] folded;

    // The product is registered; the fold and mask follow it.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= ip * HASH_MULT;
        end
    end

    assign folded = prod_reg ^ (prod_reg >> 16);
    assign slot   = folded[SLOT_BITS-1:0];
endmodule
